// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the breadth-first search block.
// Depends on clk and rst being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bfso_pkg.sv -----
// Shared types, codes and helper functions for the breadth-first search block.
// No dependencies; imported by the controller, the datapath and the top level.
package bfso_pkg;

  localparam int MASK_W = 16;
  localparam int NODE_W = 4;
  localparam int COUNT_W = 5;

  // Command codes on the cmd input
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ROW,
    ST_SCAN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_row;
    logic emit_empty;
    logic run_init;
    logic fetch;
    logic read_row;
    logic enqueue;
    logic emit_node;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_bad;
    logic pend_any;
    logic queue_empty;
  } status_t;

  // Mask with bits below n set
  function automatic logic [MASK_W-1:0] limit_mask(input logic [COUNT_W-1:0] n);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (COUNT_W'(i) < n);
    end
    return m;
  endfunction

  // Index of the lowest set bit, zero when none
  function automatic logic [NODE_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/bfs_order_with_neighbors_top.sv -----
// Top level of the breadth-first search block over adjacency bit rows.
// Depends on bfso_pkg, bfso_ctrl, bfso_datapath and assert_macros.svh.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  item in  | start & !busy         | cmd, row_index, row_bits, start_node
//  result   | valid (one cycle)     | node, neighbor_mask, found, last
//  config   | cfg_write             | cfg_data (node_count)
//
// A load item leaves busy low; a not-found run shows its single result in the
// cycle after acceptance.
// A valid run has a setup step, then per reached node a queue read, a row read,
// one scan step per neighbor enqueued and then the result.
// busy rises the cycle after a run is accepted and falls as its last result shows.
// Reset (rst, synchronous) clears node count, state and strobe; no result stalls.
`include "assert_macros.svh"

module bfs_order_with_neighbors_top #(
  parameter int MAX_NODES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [bfso_pkg::NODE_W-1:0]    row_index,
  input  logic [bfso_pkg::MASK_W-1:0]    row_bits,
  input  logic [5:0]                     start_node,
  input  logic                           cfg_write,
  input  logic [bfso_pkg::COUNT_W-1:0]   cfg_data,
  output logic                           valid,
  output logic [bfso_pkg::NODE_W-1:0]    node,
  output logic [bfso_pkg::MASK_W-1:0]    neighbor_mask,
  output logic                           found,
  output logic                           last
);
  import bfso_pkg::*;

  ctrl_t   cmds;
  status_t sts;

  // Sequence one item at a time: load, reject, or walk the visit queue
  bfso_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .cmds  (cmds),
    .busy  (busy)
  );

  // Hold rows, queue, visited mask and the result registers
  bfso_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmds          (cmds),
    .sts           (sts),
    .row_index     (row_index),
    .row_bits      (row_bits),
    .start_node    (start_node),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .valid         (valid),
    .node          (node),
    .neighbor_mask (neighbor_mask),
    .found         (found),
    .last          (last)
  );

  // After the final result of a traversal only a not-found item can follow at once
  `ASSERT_NEXT(a_last_gap, valid && last, !valid || !found,
               "found item right after the final item of a run")

endmodule

// ----- rtl/bfso_ctrl.sv -----
// Controller state machine for the breadth-first search block.
// Depends on bfso_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module bfso_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cmd,
  input  bfso_pkg::status_t sts,
  output bfso_pkg::ctrl_t   cmds,
  output logic              busy
);
  import bfso_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmds = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_LOAD) begin
            cmds.load_row = 1'b1;
          end else if (sts.run_bad) begin
            cmds.emit_empty = 1'b1;
          end else begin
            cmds.run_init = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmds.fetch = 1'b1;
        state_next = ST_ROW;
      end
      ST_ROW: begin
        cmds.read_row = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.pend_any) begin
          cmds.enqueue = 1'b1;
        end else begin
          cmds.emit_node = 1'b1;
          state_next = sts.queue_empty ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `ASSERT_IMPLIES(a_run_entry, $rose(busy), $past(start) && ($past(cmd) == CMD_RUN),
                  "run started without an accepted run item")
  `ASSERT_IMPLIES(a_no_issue_busy, busy, !cmds.load_row && !cmds.emit_empty && !cmds.run_init,
                  "item command issued while busy")

endmodule

// ----- rtl/bfso_datapath.sv -----
// Datapath of the breadth-first search block: row memory, visit queue,
// visited mask and result registers. Depends on bfso_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfso_datapath #(
  parameter int MAX_NODES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bfso_pkg::ctrl_t                cmds,
  output bfso_pkg::status_t              sts,
  input  logic [bfso_pkg::NODE_W-1:0]    row_index,
  input  logic [bfso_pkg::MASK_W-1:0]    row_bits,
  input  logic [5:0]                     start_node,
  input  logic                           cfg_write,
  input  logic [bfso_pkg::COUNT_W-1:0]   cfg_data,
  output logic                           valid,
  output logic [bfso_pkg::NODE_W-1:0]    node,
  output logic [bfso_pkg::MASK_W-1:0]    neighbor_mask,
  output logic                           found,
  output logic                           last
);
  import bfso_pkg::*;

  // Usable node count: limited by the mask width and by the storage depth
  localparam int DEPTH = (MAX_NODES < MASK_W) ? MAX_NODES : MASK_W;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH + 1);

  logic [COUNT_W-1:0] node_count;
  logic [MASK_W-1:0]  rows [DEPTH];
  logic [NODE_W-1:0]  queue [DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [MASK_W-1:0]  visited;
  logic [NODE_W-1:0]  qdata;
  logic [MASK_W-1:0]  rowdata;

  logic [COUNT_W-1:0] n_act;
  logic [MASK_W-1:0]  limit;
  logic [MASK_W-1:0]  pend;
  logic [NODE_W-1:0]  pick;

  assign n_act = (int'(node_count) > DEPTH) ? COUNT_W'(DEPTH) : node_count;
  assign limit = limit_mask(n_act);
  assign pend  = rowdata & limit & ~visited;
  assign pick  = lowest_set(pend);

  assign sts.run_bad     = (n_act == '0) || (start_node >= {1'b0, n_act});
  assign sts.pend_any    = (pend != '0);
  assign sts.queue_empty = (head == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  // Row memory: write on load, registered read at the fetched node
  always_ff @(posedge clk) begin
    if (cmds.load_row && (int'(row_index) < MAX_NODES)) begin
      rows[row_index[IDX_W-1:0]] <= row_bits;
    end
    if (cmds.read_row) begin
      rowdata <= rows[qdata[IDX_W-1:0]];
    end
  end

  // Visit queue: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (cmds.run_init) begin
      queue[0] <= start_node[NODE_W-1:0];
    end else if (cmds.enqueue) begin
      queue[tail[IDX_W-1:0]] <= pick;
    end
    if (cmds.fetch) begin
      qdata <= queue[head[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.run_init) begin
      head    <= '0;
      tail    <= PTR_W'(1);
      visited <= MASK_W'(1) << start_node[NODE_W-1:0];
    end else begin
      if (cmds.fetch) begin
        head <= head + PTR_W'(1);
      end
      if (cmds.enqueue) begin
        tail    <= tail + PTR_W'(1);
        visited <= visited | (MASK_W'(1) << pick);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmds.emit_node || cmds.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.emit_empty) begin
      node          <= '0;
      neighbor_mask <= '0;
      found         <= 1'b0;
      last          <= 1'b1;
    end else if (cmds.emit_node) begin
      node          <= qdata;
      neighbor_mask <= rowdata & limit;
      found         <= 1'b1;
      last          <= (head == tail);
    end
  end

  `ASSERT_IMPLIES(a_queue_room, cmds.enqueue, int'(tail) < DEPTH,
                  "enqueue with a full visit queue")
  `ASSERT_IMPLIES(a_empty_result, valid && !found, last && (node == '0) && (neighbor_mask == '0),
                  "not-found item with nonzero fields")

endmodule
